### src/papc_pkg.sv
// papc_pkg: constants, widths and status codes for the polygon area and
// perimeter checker
// depends on nothing; used by the channel interfaces and the top level
package papc_pkg;

  // polygon size limit and number formats
  localparam int MaxVertices   = 1024;
  localparam int CoordBits     = 24;
  localparam int PerimFracBits = 8;

  // fixed result field widths
  localparam int AreaBits  = 57;
  localparam int PerimBits = 43;
  localparam int TotalBits = 11;
  localparam int CrossBits = 59;

  // derived datapath widths
  localparam int DiffBits = CoordBits + 1;
  localparam int ProdBits = 2 * DiffBits;
  localparam int RadBits  = ProdBits + 2 * PerimFracBits;
  localparam int RootBits = RadBits / 2;
  localparam int RemBits  = RootBits + 2;
  localparam int IterBits = $clog2(RootBits);

  // multiply sequence: four products plus one drain step
  localparam int MulSteps = 5;
  localparam int StepBits = $clog2(MulSteps);

  // result status codes
  typedef enum logic [2:0] {
    StatusValid     = 3'd0,
    StatusFewPoints = 3'd1,
    StatusOrigin    = 3'd2,
    StatusDuplicate = 3'd3,
    StatusZeroArea  = 3'd4,
    StatusOverflow  = 3'd5
  } status_e;

endpackage

### src/papc_if.sv
// papc_if: valid/ready channels for vertex requests and polygon results
// depends on papc_pkg for field widths and the status type

interface papc_vertex_if import papc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] vertex_x;
  logic signed [CoordBits-1:0] vertex_y;
  logic                        is_last;

  modport source (output valid, output vertex_x, output vertex_y, output is_last,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input is_last,
                  output ready);
endinterface

interface papc_result_if import papc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AreaBits-1:0]  twice_area;
  logic [PerimBits-1:0] perimeter_fixed;
  logic [TotalBits-1:0] vertex_total;
  status_e              status;

  modport source (output valid, output twice_area, output perimeter_fixed,
                  output vertex_total, output status, input ready);
  modport sink   (input valid, input twice_area, input perimeter_fixed,
                  input vertex_total, input status, output ready);
endinterface

### src/polygon_area_perimeter_check.sv
// polygon_area_perimeter_check: shoelace area and perimeter of a closed polygon
// depends on papc_pkg and the channel interfaces in papc_if.sv
//
// Usage: vertices arrive one request at a time on vertex_i, signed x and y with
// is_last set on the final vertex. Each vertex after the first forms an edge
// with the one before it, and the last vertex also closes the polygon back to
// the first. One result leaves on result_o after each last vertex: twice the
// absolute area, the perimeter with 8 fractional bits, the vertex count and a
// status code.
// Sequence: every edge runs through one shared 25x25 multiplier for four products
// and a bit-serial square root that retires one root bit per cycle, then a
// perimeter accumulation step. A vertex that forms an edge holds vertex_i.ready
// low until its edge is finished; the first vertex and vertices past the limit
// are taken without holding it low. A last vertex adds the closing edge and a
// step that loads the result register, after which its result is valid.
// Stall: the result sits in an output register, so vertices of the next
// polygon are taken while result_o waits; the next result waits for that
// register to drain.
// Reset: rst_ni clears all polygon state and drops result_o.valid.

module polygon_area_perimeter_check import papc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  papc_vertex_if.sink    vertex_i,
  papc_result_if.source  result_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_ACC,
    ST_FINISH
  } state_e;

  // sequencer and polygon state
  state_e                      state_q, state_d;
  logic signed [CoordBits-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic signed [CoordBits-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [TotalBits-1:0]        count_q, count_d;
  logic [CrossBits-1:0]        cross_q, cross_d;
  logic [PerimBits-1:0]        perim_q, perim_d;
  logic                        nonzero_q, nonzero_d;
  logic                        dup_q, dup_d;
  logic                        ovf_q, ovf_d;
  logic                        last_q, last_d;
  logic                        closing_q, closing_d;
  logic [StepBits-1:0]         step_q, step_d;
  logic [IterBits-1:0]         iter_q, iter_d;

  // result register
  logic                 res_valid_q, res_valid_d;
  logic [AreaBits-1:0]  res_area_q, res_area_d;
  logic [PerimBits-1:0] res_perim_q, res_perim_d;
  logic [TotalBits-1:0] res_total_q, res_total_d;
  status_e              res_status_q, res_status_d;

  // edge datapath
  logic signed [CoordBits-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic signed [DiffBits-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic signed [ProdBits-1:0]  prod_q, prod_d;
  logic [ProdBits-1:0]         sq_q, sq_d;
  logic [RadBits-1:0]          rad_q, rad_d;
  logic [RemBits-1:0]          rem_q, rem_d;
  logic [RootBits-1:0]         root_q, root_d;

  // combinational helpers
  logic                        accept;
  logic                        at_limit;
  logic                        load_en, load_closing;
  logic signed [CoordBits-1:0] ld_ax, ld_ay, ld_bx, ld_by;
  logic signed [DiffBits-1:0]  mul_a, mul_b;
  logic signed [ProdBits-1:0]  mul_p;
  logic [RemBits+1:0]          rem_sh, trial, rem_sub;
  logic [PerimBits:0]          perim_sum;
  logic [CrossBits-1:0]        cross_mag;
  logic                        res_free;

  assign vertex_i.ready = (state_q == ST_IDLE);
  assign accept         = vertex_i.valid && vertex_i.ready;
  assign at_limit       = (count_q == TotalBits'(MaxVertices));
  assign res_free       = !res_valid_q || result_o.ready;

  // shared multiplier, operands picked by the step counter
  always_comb begin
    case (step_q[1:0])
      2'd0:    begin mul_a = dx_q;                      mul_b = dx_q; end
      2'd1:    begin mul_a = dy_q;                      mul_b = dy_q; end
      2'd2:    begin mul_a = {ax_q[CoordBits-1], ax_q}; mul_b = {by_q[CoordBits-1], by_q}; end
      default: begin mul_a = {bx_q[CoordBits-1], bx_q}; mul_b = {ay_q[CoordBits-1], ay_q}; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one square-root step: bring down two radicand bits, try the next root bit
  assign rem_sh  = {rem_q, rad_q[RadBits-1 -: 2]};
  assign trial   = {{(RemBits - RootBits){1'b0}}, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;

  // saturating perimeter add and shoelace magnitude
  assign perim_sum = {1'b0, perim_q} + (PerimBits + 1)'(root_q);
  assign cross_mag = cross_q[CrossBits-1] ? (~cross_q + CrossBits'(1)) : cross_q;

  // sequencer and next-state logic
  always_comb begin
    state_d      = state_q;
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    count_d      = count_q;
    cross_d      = cross_q;
    perim_d      = perim_q;
    nonzero_d    = nonzero_q;
    dup_d        = dup_q;
    ovf_d        = ovf_q;
    last_d       = last_q;
    closing_d    = closing_q;
    step_d       = step_q;
    iter_d       = iter_q;
    res_valid_d  = res_valid_q;
    res_area_d   = res_area_q;
    res_perim_d  = res_perim_q;
    res_total_d  = res_total_q;
    res_status_d = res_status_q;
    ax_d         = ax_q;
    ay_d         = ay_q;
    bx_d         = bx_q;
    by_d         = by_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    prod_d       = prod_q;
    sq_d         = sq_q;
    rad_d        = rad_q;
    rem_d        = rem_q;
    root_d       = root_q;
    load_en      = 1'b0;
    load_closing = 1'b0;

    if (res_valid_q && result_o.ready) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d    = vertex_i.is_last;
          closing_d = 1'b0;
          if (at_limit) begin
            ovf_d = 1'b1;
          end else begin
            if (count_q == '0) begin
              first_x_d = vertex_i.vertex_x;
              first_y_d = vertex_i.vertex_y;
            end else begin
              load_en = 1'b1;
            end
            prev_x_d = vertex_i.vertex_x;
            prev_y_d = vertex_i.vertex_y;
            count_d  = count_q + TotalBits'(1);
            if (vertex_i.vertex_x != '0 || vertex_i.vertex_y != '0) begin
              nonzero_d = 1'b1;
            end
          end
          // no edge of its own: go straight to the closing edge
          if (!load_en && vertex_i.is_last) begin
            load_en      = 1'b1;
            load_closing = 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod_d = mul_p;
        step_d = step_q + StepBits'(1);
        case (step_q)
          StepBits'(1): sq_d = $unsigned(prod_q);
          StepBits'(2): sq_d = sq_q + $unsigned(prod_q);
          StepBits'(3): cross_d = cross_q +
                          {{(CrossBits - ProdBits){prod_q[ProdBits-1]}}, prod_q};
          StepBits'(4): begin
            cross_d = cross_q - {{(CrossBits - ProdBits){prod_q[ProdBits-1]}}, prod_q};
            rad_d   = {sq_q, {(2 * PerimFracBits){1'b0}}};
            rem_d   = '0;
            root_d  = '0;
            iter_d  = '0;
            state_d = ST_ROOT;
          end
          default: ;
        endcase
      end
      ST_ROOT: begin
        rad_d  = rad_q << 2;
        iter_d = iter_q + IterBits'(1);
        if (rem_sh >= trial) begin
          rem_d  = rem_sub[RemBits-1:0];
          root_d = {root_q[RootBits-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[RemBits-1:0];
          root_d = {root_q[RootBits-2:0], 1'b0};
        end
        if (iter_q == IterBits'(RootBits - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        perim_d = perim_sum[PerimBits] ? {PerimBits{1'b1}} : perim_sum[PerimBits-1:0];
        if (last_q && !closing_q) begin
          load_en      = 1'b1;
          load_closing = 1'b1;
        end else if (last_q) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          res_valid_d = 1'b1;
          res_total_d = count_q;
          res_area_d  = '0;
          res_perim_d = '0;
          if (ovf_q) begin
            res_status_d = StatusOverflow;
          end else if (count_q < TotalBits'(3)) begin
            res_status_d = StatusFewPoints;
          end else begin
            res_area_d  = (cross_mag[CrossBits-1:AreaBits] != '0) ?
                          {AreaBits{1'b1}} : cross_mag[AreaBits-1:0];
            res_perim_d = perim_q;
            if (!nonzero_q) begin
              res_status_d = StatusOrigin;
            end else if (dup_q) begin
              res_status_d = StatusDuplicate;
            end else if (cross_q == '0) begin
              res_status_d = StatusZeroArea;
            end else begin
              res_status_d = StatusValid;
            end
          end
          // clear polygon state for the next request
          first_x_d = '0;
          first_y_d = '0;
          prev_x_d  = '0;
          prev_y_d  = '0;
          count_d   = '0;
          cross_d   = '0;
          perim_d   = '0;
          nonzero_d = 1'b0;
          dup_d     = 1'b0;
          ovf_d     = 1'b0;
          last_d    = 1'b0;
          closing_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // edge operand load: running edge from the old previous vertex, or the
    // closing edge from the (updated) previous vertex back to the first
    ld_ax = load_closing ? prev_x_d  : prev_x_q;
    ld_ay = load_closing ? prev_y_d  : prev_y_q;
    ld_bx = load_closing ? first_x_d : vertex_i.vertex_x;
    ld_by = load_closing ? first_y_d : vertex_i.vertex_y;
    if (load_en) begin
      ax_d    = ld_ax;
      ay_d    = ld_ay;
      bx_d    = ld_bx;
      by_d    = ld_by;
      dx_d    = {ld_bx[CoordBits-1], ld_bx} - {ld_ax[CoordBits-1], ld_ax};
      dy_d    = {ld_by[CoordBits-1], ld_by} - {ld_ay[CoordBits-1], ld_ay};
      dup_d   = dup_d || ((ld_ax == ld_bx) && (ld_ay == ld_by));
      step_d  = '0;
      if (load_closing) begin
        closing_d = 1'b1;
      end
      state_d = ST_MUL;
    end
  end

  // state, polygon totals and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      count_q      <= '0;
      cross_q      <= '0;
      perim_q      <= '0;
      nonzero_q    <= 1'b0;
      dup_q        <= 1'b0;
      ovf_q        <= 1'b0;
      last_q       <= 1'b0;
      closing_q    <= 1'b0;
      step_q       <= '0;
      iter_q       <= '0;
      res_valid_q  <= 1'b0;
      res_area_q   <= '0;
      res_perim_q  <= '0;
      res_total_q  <= '0;
      res_status_q <= StatusValid;
    end else begin
      state_q      <= state_d;
      first_x_q    <= first_x_d;
      first_y_q    <= first_y_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      count_q      <= count_d;
      cross_q      <= cross_d;
      perim_q      <= perim_d;
      nonzero_q    <= nonzero_d;
      dup_q        <= dup_d;
      ovf_q        <= ovf_d;
      last_q       <= last_d;
      closing_q    <= closing_d;
      step_q       <= step_d;
      iter_q       <= iter_d;
      res_valid_q  <= res_valid_d;
      res_area_q   <= res_area_d;
      res_perim_q  <= res_perim_d;
      res_total_q  <= res_total_d;
      res_status_q <= res_status_d;
    end
  end

  // edge datapath registers
  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    prod_q <= prod_d;
    sq_q   <= sq_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // result channel
  assign result_o.valid           = res_valid_q;
  assign result_o.twice_area      = res_area_q;
  assign result_o.perimeter_fixed = res_perim_q;
  assign result_o.vertex_total    = res_total_q;
  assign result_o.status          = res_status_q;

  // vertex count never passes the limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TotalBits'(MaxVertices))
    else $error("vertex count above limit");

  // root iteration stays within the root width
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (iter_q < IterBits'(RootBits)))
    else $error("square root iteration out of range");

  // restoring remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> ({1'b0, rem_q} <= {2'b00, root_q, 1'b0}))
    else $error("square root remainder too large");

  // overflow and short polygons report no area or perimeter
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_status_q == StatusOverflow || res_status_q == StatusFewPoints))
    |-> (res_area_q == '0 && res_perim_q == '0))
    else $error("rejected polygon carries area or perimeter");

  // a finished polygon clears its state and frees the vertex channel
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && res_free) |=>
    (state_q == ST_IDLE && count_q == '0 && res_valid_q))
    else $error("polygon state not cleared after result");

endmodule
